FILE: rtl/core/cle_pkg.sv
// Shared types, constants and helpers of the console line editor.
package cle_pkg;

  localparam int LINE_DEPTH = 64;
  localparam int POS_W      = $clog2(LINE_DEPTH);

  localparam logic [7:0] KEY_BACKSPACE = 8'd127;
  localparam logic [7:0] KEY_RETURN    = 8'd13;
  localparam logic [7:0] CHAR_BS       = 8'd8;
  localparam logic [7:0] CHAR_SPACE    = 8'd32;
  localparam logic [7:0] CHAR_LF       = 8'd10;

  typedef enum logic [1:0] {
    OP_RX   = 2'd0,
    OP_READ = 2'd1,
    OP_POLL = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_ECHO = 3'd0,
    KIND_BS   = 3'd1,
    KIND_CR   = 3'd2,
    KIND_READ = 3'd3,
    KIND_POLL = 3'd4
  } kind_t;

  function automatic logic [1:0] result_count(input kind_t kind);
    logic [1:0] cnt;
    unique case (kind)
      KIND_BS: cnt = 2'd3;
      KIND_CR: cnt = 2'd2;
      default: cnt = 2'd1;
    endcase
    return cnt;
  endfunction

endpackage

FILE: rtl/core/console_line_editor_unit.sv
// Console line editor: echo, line store editing, store read and command poll.
//
// channel | dir | tvalid/tready  | payload
// s_axis  | in  | s_axis_tvalid  | tuser: op; tdata: rx_byte, read_index
// m_axis  | out | m_axis_tvalid  | tdata: tx_byte, tx_valid, read_data, command_pending;
//         |     |                | tlast: last
//
// An item is taken every cycle the input register is free and leaves the result
// register one result per cycle while m_axis_tready is high: one result for a plain
// echo, read or poll, two for a carriage return, three for a backspace; the result
// register sets the rate. Items go from the input register to the result register.
// After reset, per-entry valid bits make the store read as zero.
// A stalled output holds its result and the input register behind it.
module console_line_editor_unit
  import cle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] rx_byte, [13:8] read_index, [15:14] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [7:0] tx_byte, [8] tx_valid, [16:9] read_data,
                                     // [17] command_pending, [23:18] zero
  output logic        m_axis_tlast
);

  logic             s_fire;
  op_t              s_op;
  logic [7:0]       s_byte;
  logic [5:0]       s_idx;
  logic [POS_W-1:0] rd_addr;
  logic             read_ok;

  logic [POS_W-1:0] fill_position, fill_position_next;
  logic             pending_flag, pending_flag_next;
  logic [LINE_DEPTH-1:0] line_vld;

  logic             wr_en;
  logic [7:0]       wr_data;
  logic [7:0]       ram_q;

  logic             a_vld;
  kind_t            a_kind;
  logic [7:0]       a_byte;
  logic             a_cp;
  logic             a_rd_ok;
  logic             a_load;
  kind_t            a_kind_next;
  logic             a_to_b;

  logic             b_vld;
  kind_t            b_kind;
  logic [1:0]       b_step;
  logic [7:0]       b_byte;
  logic [7:0]       b_rd;
  logic             b_cp;
  logic             b_last;
  logic             m_fire;

  logic [7:0]       m_tx_byte;
  logic             m_tx_valid;
  logic [7:0]       m_read_data;
  logic             m_cmd_pending;

  assign s_op    = op_t'(s_axis_tuser);
  assign s_byte  = s_axis_tdata[7:0];
  assign s_idx   = s_axis_tdata[13:8];
  assign rd_addr = POS_W'(s_idx);
  assign read_ok = 32'(s_idx) < LINE_DEPTH;

  assign a_to_b        = a_vld && (!b_vld || (m_axis_tready && b_last));
  assign s_axis_tready = !a_vld || a_to_b;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;

  always_comb begin
    fill_position_next = fill_position;
    pending_flag_next  = pending_flag;
    wr_en              = 1'b0;
    wr_data            = 8'd0;
    a_load             = 1'b0;
    a_kind_next        = KIND_ECHO;
    if (s_fire) begin
      unique case (s_op)
        OP_RX: begin
          a_load = 1'b1;
          priority if (s_byte == KEY_BACKSPACE) begin
            a_kind_next = KIND_BS;
            wr_en       = 1'b1;
            if (fill_position != '0) begin
              fill_position_next = fill_position - 1'b1;
            end
          end else if (s_byte == KEY_RETURN) begin
            a_kind_next        = KIND_CR;
            wr_en              = 1'b1;
            fill_position_next = '0;
            pending_flag_next  = 1'b1;
          end else begin
            a_kind_next = KIND_ECHO;
            if (fill_position < POS_W'(LINE_DEPTH - 1)) begin
              wr_en              = 1'b1;
              wr_data            = s_byte;
              fill_position_next = fill_position + 1'b1;
            end
          end
        end
        OP_READ: begin
          a_load      = 1'b1;
          a_kind_next = KIND_READ;
        end
        OP_POLL: begin
          a_load            = 1'b1;
          a_kind_next       = KIND_POLL;
          pending_flag_next = 1'b0;
        end
        OP_NONE: begin
          a_load = 1'b0;
        end
        default: begin
          a_load = 1'b0;
        end
      endcase
    end
  end

  cle_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_position),
    .wr_data (wr_data),
    .rd_en   (s_fire),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_position <= '0;
      pending_flag  <= 1'b0;
      line_vld      <= '0;
    end else begin
      fill_position <= fill_position_next;
      pending_flag  <= pending_flag_next;
      if (wr_en) begin
        line_vld[fill_position] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (s_fire) begin
      a_vld <= a_load;
    end else if (a_to_b) begin
      a_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      a_kind  <= a_kind_next;
      a_byte  <= s_byte;
      a_cp    <= pending_flag;
      a_rd_ok <= read_ok && line_vld[rd_addr];
    end
  end

  assign b_last = b_step == (result_count(b_kind) - 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld  <= 1'b0;
      b_step <= '0;
    end else if (a_to_b) begin
      b_vld  <= 1'b1;
      b_step <= '0;
    end else if (m_fire) begin
      if (b_last) begin
        b_vld <= 1'b0;
      end else begin
        b_step <= b_step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_to_b) begin
      b_kind <= a_kind;
      b_byte <= a_byte;
      b_cp   <= a_cp;
      b_rd   <= a_rd_ok ? ram_q : 8'd0;
    end
  end

  always_comb begin
    m_tx_byte     = 8'd0;
    m_tx_valid    = 1'b0;
    m_read_data   = 8'd0;
    m_cmd_pending = 1'b0;
    unique case (b_kind)
      KIND_ECHO: begin
        m_tx_byte  = b_byte;
        m_tx_valid = 1'b1;
      end
      KIND_BS: begin
        m_tx_byte  = (b_step == 2'd1) ? CHAR_SPACE : CHAR_BS;
        m_tx_valid = 1'b1;
      end
      KIND_CR: begin
        m_tx_byte  = (b_step == 2'd0) ? KEY_RETURN : CHAR_LF;
        m_tx_valid = 1'b1;
      end
      KIND_READ: begin
        m_read_data = b_rd;
      end
      KIND_POLL: begin
        m_cmd_pending = b_cp;
      end
      default: begin
        m_tx_valid = 1'b0;
      end
    endcase
  end

  assign m_axis_tvalid = b_vld;
  assign m_axis_tlast  = b_last;
  assign m_axis_tdata  = {6'd0, m_cmd_pending, m_read_data, m_tx_valid, m_tx_byte};

  a_return_clears_fill: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_op == OP_RX && s_byte == KEY_RETURN |=> fill_position == '0)
    else $error("fill position not cleared after carriage return");

  a_poll_clears_flag: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_op == OP_POLL |=> !pending_flag)
    else $error("pending flag not cleared after poll");

  a_echo_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_tx_valid |-> m_read_data == 8'd0 && !m_cmd_pending)
    else $error("echo result carries read or poll data");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> a_vld && b_vld)
    else $error("input stalled with a free stage");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    b_vld |-> b_step < result_count(b_kind))
    else $error("result step beyond result count");

endmodule

FILE: rtl/core/cle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
